>>> src/first_fit_segment_allocator_top_assert.svh
// Assertion macros for the segment allocator.
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Property checked on every rising clock edge outside reset.
`define FFSA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication checked on every rising clock edge outside reset.
`define FFSA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define FFSA_ASSERT(label, clk, rst_n, prop, msg)
`define FFSA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> src/ffsa_pkg.sv
// Shared types and constants of the segment allocator.
`default_nettype none
package ffsa_pkg;
    localparam int OFFSET_BITS  = 30;
    localparam int LEN_BITS     = OFFSET_BITS + 1;
    localparam int NEED_BITS    = LEN_BITS + 1;
    localparam int POOL_BITS    = 11;
    localparam int MAX_ALLOCS_D = 64;
    localparam int FREE_SLOTS_D = 65;
    localparam logic [POOL_BITS-1:0] POOL_MAX_MB = 11'd1024;
    localparam logic [LEN_BITS-1:0]  POOL_LIMIT  = 31'h4000_0000;

    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_FREE   = 2'd1;
    localparam logic [1:0] CMD_RESET  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOFIT    = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_ZERO     = 3'd4;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] base;
        logic [LEN_BITS-1:0]    len;
    } t_seg;

    localparam int SEG_W = OFFSET_BITS + LEN_BITS;
endpackage
`default_nettype wire

>>> src/ffsa_ram.sv
// Generic simple dual-port RAM with registered read (old data on collision).
`default_nettype none
module ffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

>>> src/first_fit_segment_allocator_top.sv
// Top level of the first-fit segment allocator with coalescing.
`default_nettype none
// The block keeps free segments of a byte pool in an address-ordered RAM and
// live allocations in a second RAM, and runs one command at a time under a
// small sequencer that reads one RAM entry per cycle. A command is a beat
// taken while o_ready is high; it yields exactly one result beat. A zero size
// or an unknown command goes straight to the result. A reset pool command
// rewrites the free table. An allocate scans the allocation slots up to the
// first free one (all of them when the table is full), then the free segments
// up to the first fit (all of them when nothing fits), and when a segment is
// used up exactly it shifts the segments above it down. A free scans the
// allocation slots up to the match (all of them when not found), then the
// free segments below the offset; an insert then shifts the segments above it
// up, and a two-sided merge shifts the segments above it down. A waiting
// result stalls the sequencer before it returns to idle. The pool size
// register is sampled only at a reset command or hardware reset, which also
// writes the first free segment before the first command is taken. The
// result sits in an output register, so a new command is taken while the
// previous result is still waiting.
module first_fit_segment_allocator_top #(
    parameter int MAX_ALLOCS = ffsa_pkg::MAX_ALLOCS_D,
    parameter int FREE_SLOTS = ffsa_pkg::FREE_SLOTS_D
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [10:0] i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_command,
    input  wire logic [30:0] i_alloc_size,
    input  wire logic [3:0]  i_align_log2,
    input  wire logic [29:0] i_block_offset,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic      [29:0] o_result_offset,
    output logic      [2:0]  o_status,
    output logic      [30:0] o_used_bytes
);
`include "first_fit_segment_allocator_top_assert.svh"

    localparam int AW = $clog2(MAX_ALLOCS);
    localparam int PW = $clog2(FREE_SLOTS + 1);
    localparam int OB = ffsa_pkg::OFFSET_BITS;
    localparam int LB = ffsa_pkg::LEN_BITS;
    localparam int NB = ffsa_pkg::NEED_BITS;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_INIT  = 10'b00_0000_0010,
        S_ASLOT = 10'b00_0000_0100,
        S_AFIT  = 10'b00_0000_1000,
        S_SHDN  = 10'b00_0001_0000,
        S_FFIND = 10'b00_0010_0000,
        S_FPOS  = 10'b00_0100_0000,
        S_SHUP  = 10'b00_1000_0000,
        S_INS   = 10'b01_0000_0000,
        S_FIN   = 10'b10_0000_0000
    } t_state;

    t_state                 r_st, n_st;
    logic                   r_boot, n_boot;
    logic [10:0]            r_pool;
    logic [PW-1:0]          r_cnt, n_cnt;
    logic [LB-1:0]          r_used, n_used;
    logic [MAX_ALLOCS-1:0]  r_valid, n_valid;
    logic                   r_ovalid, n_ovalid;
    // command working registers (no reset needed)
    logic [NB-1:0]          r_need, n_need;
    logic [OB-1:0]          r_off, n_off;
    logic [LB-1:0]          r_len, n_len;
    logic [AW-1:0]          r_slot, n_slot;
    logic [AW-1:0]          r_aptr, n_aptr;
    logic [PW-1:0]          r_ptr, n_ptr;
    logic [PW-1:0]          r_p, n_p;
    ffsa_pkg::t_seg         r_prev, n_prev;
    logic [OB-1:0]          r_fres, n_fres;
    logic [2:0]             r_fst, n_fst;
    logic [OB-1:0]          r_ores, n_ores;
    logic [2:0]             r_ostat, n_ostat;
    logic [LB-1:0]          r_oused, n_oused;

    // free segment table port
    logic                   f_we;
    logic [PW-1:0]          f_waddr;
    ffsa_pkg::t_seg         f_wdata, f_rd;
    // allocation table port
    logic                   a_we;
    ffsa_pkg::t_seg         a_wdata, a_rd;

    logic [LB-1:0]          pool_bytes;
    logic [NB-1:0]          mask;
    logic [LB-1:0]          prev_end, blk_end;
    logic                   has_prev, has_next;

    ffsa_ram #(.WIDTH(ffsa_pkg::SEG_W), .DEPTH(FREE_SLOTS + 1)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_raddr (n_ptr),
        .o_rdata (f_rd)
    );

    ffsa_ram #(.WIDTH(ffsa_pkg::SEG_W), .DEPTH(MAX_ALLOCS)) u_alloc_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (r_slot),
        .i_wdata (a_wdata),
        .i_raddr (n_aptr),
        .o_rdata (a_rd)
    );

    // saturate pool at 2^OFFSET_BITS bytes
    assign pool_bytes = (r_pool > ffsa_pkg::POOL_MAX_MB) ? ffsa_pkg::POOL_LIMIT
                                                         : {r_pool, 20'd0};
    assign mask       = (NB'(1) << i_align_log2) - NB'(1);
    assign prev_end   = {1'b0, r_prev.base} + r_prev.len;
    assign blk_end    = {1'b0, r_off} + r_len;
    assign has_prev   = (r_ptr != '0) && (prev_end == {1'b0, r_off});
    assign has_next   = (r_ptr < r_cnt) && (blk_end == {1'b0, f_rd.base});

    assign o_ready         = (r_st == S_IDLE);
    assign o_valid         = r_ovalid;
    assign o_result_offset = r_ores;
    assign o_status        = r_ostat;
    assign o_used_bytes    = r_oused;

    always_comb begin
        n_st     = r_st;
        n_boot   = r_boot;
        n_cnt    = r_cnt;
        n_used   = r_used;
        n_valid  = r_valid;
        n_ovalid = r_ovalid;
        n_need   = r_need;
        n_off    = r_off;
        n_len    = r_len;
        n_slot   = r_slot;
        n_aptr   = r_aptr;
        n_ptr    = r_ptr;
        n_p      = r_p;
        n_prev   = r_prev;
        n_fres   = r_fres;
        n_fst    = r_fst;
        n_ores   = r_ores;
        n_ostat  = r_ostat;
        n_oused  = r_oused;
        f_we     = 1'b0;
        f_waddr  = r_ptr;
        f_wdata  = f_rd;
        a_we     = 1'b0;
        a_wdata  = '{base: f_rd.base, len: r_need[LB-1:0]};

        if (i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_st)
            S_IDLE: begin
                if (i_valid) begin
                    n_fres = '0;
                    n_fst  = ffsa_pkg::ST_OK;
                    case (i_command)
                        ffsa_pkg::CMD_ALLOC: begin
                            if (i_alloc_size == '0) begin
                                n_fst = ffsa_pkg::ST_ZERO;
                                n_st  = S_FIN;
                            end else begin
                                n_need = ({1'b0, i_alloc_size} + mask) & ~mask;
                                n_aptr = '0;
                                n_st   = S_ASLOT;
                            end
                        end
                        ffsa_pkg::CMD_FREE: begin
                            n_off  = i_block_offset;
                            n_aptr = '0;
                            n_st   = S_FFIND;
                        end
                        ffsa_pkg::CMD_RESET: begin
                            n_st = S_INIT;
                        end
                        default: begin
                            n_st = S_FIN;
                        end
                    endcase
                end
            end
            S_INIT: begin
                f_we    = 1'b1;
                f_waddr = '0;
                f_wdata = '{base: '0, len: pool_bytes};
                n_cnt   = (pool_bytes != '0) ? PW'(1) : '0;
                n_valid = '0;
                n_used  = '0;
                n_boot  = 1'b0;
                n_st    = r_boot ? S_IDLE : S_FIN;
            end
            S_ASLOT: begin
                if (!r_valid[r_aptr]) begin
                    n_slot = r_aptr;
                    n_ptr  = '0;
                    n_st   = S_AFIT;
                end else if (r_aptr == AW'(MAX_ALLOCS - 1)) begin
                    n_fst = ffsa_pkg::ST_FULL;
                    n_st  = S_FIN;
                end else begin
                    n_aptr = r_aptr + AW'(1);
                end
            end
            S_AFIT: begin
                if (r_ptr >= r_cnt) begin
                    n_fst = ffsa_pkg::ST_NOFIT;
                    n_st  = S_FIN;
                end else if ({1'b0, f_rd.len} >= r_need) begin
                    a_we             = 1'b1;
                    n_valid[r_slot]  = 1'b1;
                    n_used           = r_used + r_need[LB-1:0];
                    n_fres           = f_rd.base;
                    if ({1'b0, f_rd.len} > r_need) begin
                        // split: remainder stays in place
                        f_we    = 1'b1;
                        f_wdata = '{base: f_rd.base + r_need[OB-1:0],
                                    len:  f_rd.len - r_need[LB-1:0]};
                        n_st    = S_FIN;
                    end else begin
                        n_ptr = r_ptr + PW'(1);
                        n_st  = S_SHDN;
                    end
                end else begin
                    n_ptr = r_ptr + PW'(1);
                end
            end
            S_SHDN: begin
                // close the gap: entry r_ptr moves down to r_ptr-1
                if (r_ptr < r_cnt) begin
                    f_we    = 1'b1;
                    f_waddr = r_ptr - PW'(1);
                    n_ptr   = r_ptr + PW'(1);
                end else begin
                    n_cnt = r_cnt - PW'(1);
                    n_st  = S_FIN;
                end
            end
            S_FFIND: begin
                if (r_valid[r_aptr] && (a_rd.base == r_off)) begin
                    n_len  = a_rd.len;
                    n_slot = r_aptr;
                    n_ptr  = '0;
                    n_st   = S_FPOS;
                end else if (r_aptr == AW'(MAX_ALLOCS - 1)) begin
                    n_fst = ffsa_pkg::ST_NOTFOUND;
                    n_st  = S_FIN;
                end else begin
                    n_aptr = r_aptr + AW'(1);
                end
            end
            S_FPOS: begin
                if ((r_ptr < r_cnt) && (f_rd.base < r_off)) begin
                    n_prev = f_rd;
                    n_ptr  = r_ptr + PW'(1);
                end else begin
                    n_p = r_ptr;
                    if (!has_prev && !has_next && (r_cnt >= PW'(FREE_SLOTS))) begin
                        n_fst = ffsa_pkg::ST_FULL;
                        n_st  = S_FIN;
                    end else begin
                        n_valid[r_slot] = 1'b0;
                        n_used          = r_used - r_len;
                        if (has_prev && has_next) begin
                            f_we    = 1'b1;
                            f_waddr = r_ptr - PW'(1);
                            f_wdata = '{base: r_prev.base,
                                        len:  r_prev.len + r_len + f_rd.len};
                            n_ptr   = r_ptr + PW'(1);
                            n_st    = S_SHDN;
                        end else if (has_prev) begin
                            f_we    = 1'b1;
                            f_waddr = r_ptr - PW'(1);
                            f_wdata = '{base: r_prev.base, len: r_prev.len + r_len};
                            n_st    = S_FIN;
                        end else if (has_next) begin
                            f_we    = 1'b1;
                            f_wdata = '{base: r_off, len: f_rd.len + r_len};
                            n_st    = S_FIN;
                        end else if (r_cnt > r_ptr) begin
                            n_ptr = r_cnt - PW'(1);
                            n_st  = S_SHUP;
                        end else begin
                            n_st = S_INS;
                        end
                    end
                end
            end
            S_SHUP: begin
                // open a hole at r_p: entry r_ptr moves up to r_ptr+1
                f_we    = 1'b1;
                f_waddr = r_ptr + PW'(1);
                if (r_ptr == r_p) begin
                    n_st = S_INS;
                end else begin
                    n_ptr = r_ptr - PW'(1);
                end
            end
            S_INS: begin
                f_we    = 1'b1;
                f_waddr = r_p;
                f_wdata = '{base: r_off, len: r_len};
                n_cnt   = r_cnt + PW'(1);
                n_st    = S_FIN;
            end
            S_FIN: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_ores   = r_fres;
                    n_ostat  = r_fst;
                    n_oused  = r_used;
                    n_st     = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_INIT;
            r_boot   <= 1'b1;
            r_pool   <= 11'd1;
            r_cnt    <= '0;
            r_used   <= '0;
            r_valid  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_boot   <= n_boot;
            r_cnt    <= n_cnt;
            r_used   <= n_used;
            r_valid  <= n_valid;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_pool <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_need  <= n_need;
        r_off   <= n_off;
        r_len   <= n_len;
        r_slot  <= n_slot;
        r_aptr  <= n_aptr;
        r_ptr   <= n_ptr;
        r_p     <= n_p;
        r_prev  <= n_prev;
        r_fres  <= n_fres;
        r_fst   <= n_fst;
        r_ores  <= n_ores;
        r_ostat <= n_ostat;
        r_oused <= n_oused;
    end

    `FFSA_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= PW'(FREE_SLOTS), "free count overflow")
    `FFSA_ASSERT(a_used_bound, i_clk, i_rst_n, r_used <= ffsa_pkg::POOL_LIMIT, "used over pool")
    `FFSA_ASSERT_IMP(a_wr_inside, i_clk, i_rst_n, f_we, f_waddr <= r_cnt, "free write past end")
    `FFSA_ASSERT_IMP(a_res_fin, i_clk, i_rst_n, $rose(r_ovalid), $past(r_st == S_FIN), "stray result")
endmodule
`default_nettype wire
